// ===== design/natwr_pkg.sv =====
// ----------------------------------------------------------------------------
// NAT wildcard rule lookup package
// Shared widths, codes and the cell result type.
// ----------------------------------------------------------------------------
package natwr_pkg;

  localparam int IpW   = 32;
  localparam int PortW = 16;
  localparam int ValW  = IpW + PortW;

  localparam int DefExactEntries = 64;
  localparam int DefAddrEntries  = 64;
  localparam int DefPortEntries  = 64;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISS     = 2'd1,
    ST_REPLACED = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_EXACT = 2'd0,
    KIND_ADDR  = 2'd1,
    KIND_PORT  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Search word handed along the chain of cells.
  typedef struct packed {
    logic            hit;
    logic            free_seen;
    logic [ValW-1:0] value;
  } chain_t;

  // Broadcast command to every cell of a table.
  typedef struct packed {
    logic            search;
    logic            write;
    logic            wr_free;
    logic [ValW-1:0] key;
    logic [ValW-1:0] value;
  } cell_cmd_t;

endpackage

// ===== design/natwr_cell.sv =====
// ----------------------------------------------------------------------------
// NAT rule cell
// One table entry: compares the broadcast key, passes hit and first-free
// information to the next cell, and writes on replace or claim.
// ----------------------------------------------------------------------------
module natwr_cell import natwr_pkg::*; #(
  parameter int KeyW = 48
) (
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_t cmd,
  input  chain_t    chain_in,
  output chain_t    chain_out
);

  logic            valid;
  logic [KeyW-1:0] key;
  logic [ValW-1:0] value;
  logic            match;
  logic            claim;

  assign match = valid && (key == cmd.key[KeyW-1:0]);
  // first free cell is the one with no free cell before it
  assign claim = !valid && !chain_in.free_seen;

  // Pass hit value along, first hit wins (keys are unique anyway).
  always_comb begin
    chain_out = chain_in;
    if (!chain_in.hit && match) begin
      chain_out.hit   = 1'b1;
      chain_out.value = value;
    end
    if (!valid) chain_out.free_seen = 1'b1;
  end

  // Hold the valid bit; set on claim of a free entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.write && cmd.wr_free && claim) begin
      valid <= 1'b1;
    end
  end

  // Write key and value on claim or replace.
  always_ff @(posedge clk) begin
    if (cmd.write && ((cmd.wr_free && claim) || (!cmd.wr_free && match))) begin
      key   <= cmd.key[KeyW-1:0];
      value <= cmd.value;
    end
  end

endmodule

// ===== design/natwr_table.sv =====
// ----------------------------------------------------------------------------
// NAT rule table
// A chain of rule cells; reports hit, the hit value and whether a free
// entry exists.
// ----------------------------------------------------------------------------
module natwr_table import natwr_pkg::*; #(
  parameter int Entries = 64,
  parameter int KeyW    = 48
) (
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_t cmd,
  output chain_t    result
);

  chain_t links [Entries+1];

  assign links[0] = '0;

  for (genvar g = 0; g < Entries; g++) begin : g_cell
    natwr_cell #(.KeyW(KeyW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .chain_in (links[g]),
      .chain_out(links[g+1])
    );
  end

  assign result = links[Entries];

endmodule

// ===== design/nat_wildcard_rule_lookup_core.sv =====
// ----------------------------------------------------------------------------
// NAT wildcard rule lookup core
// Three rule tables (exact, address-any-port, port-any-address) built from
// chains of match cells.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the item fields and pulse start while busy is low. Each item
//   goes through a search phase and then a write phase: the search phase
//   searches all three cell chains at once and registers the outcome; the
//   write phase writes the insert (replace in place or claim the lowest
//   free entry) and shows the result for one cycle with done high. busy is
//   high during the write phase, so a new item is taken only once the last
//   is through; the item rate is set by the search-then-write pass.
//   Inserts report added, replaced, table full or, for kind none, a miss;
//   lookups report the first hit in exact, address, port order, or a miss
//   with zero fields. Reset clears every valid bit and drops any item in
//   work. The receiver cannot stall: done lasts exactly one cycle.
// ----------------------------------------------------------------------------
module nat_wildcard_rule_lookup_core import natwr_pkg::*; #(
  parameter int EXACT_ENTRIES = DefExactEntries,
  parameter int ADDR_ENTRIES  = DefAddrEntries,
  parameter int PORT_ENTRIES  = DefPortEntries
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              cmd,
  input  logic [1:0]        rule_kind,
  input  logic [IpW-1:0]    match_ip,
  input  logic [PortW-1:0]  match_port,
  input  logic [IpW-1:0]    new_ip,
  input  logic [PortW-1:0]  new_port,
  output logic              done,
  output logic [1:0]        status,
  output logic [1:0]        matched_kind,
  output logic [IpW-1:0]    out_ip,
  output logic [PortW-1:0]  out_port
);

  // Latched item.
  logic             phase;
  logic             op;
  logic [1:0]       kind;
  logic [IpW-1:0]   ip_q;
  logic [PortW-1:0] port_q;
  logic [ValW-1:0]  nv_q;
  // Registered search outcome.
  logic             ex_hit, ad_hit, pt_hit;
  logic             ex_free, ad_free, pt_free;
  logic [ValW-1:0]  ex_val, ad_val, pt_val;
  // Key under search: the input ports while idle, the latched item after.
  logic [IpW-1:0]   ip_s;
  logic [PortW-1:0] port_s;

  cell_cmd_t ex_cmd, ad_cmd, pt_cmd;
  chain_t    ex_res, ad_res, pt_res;

  assign busy   = phase;
  assign ip_s   = phase ? ip_q : match_ip;
  assign port_s = phase ? port_q : match_port;

  // Broadcast key and write controls; writes happen only in phase two.
  always_comb begin
    ex_cmd = '0;
    ad_cmd = '0;
    pt_cmd = '0;
    ex_cmd.key   = {ip_s, port_s};
    ad_cmd.key   = {{PortW{1'b0}}, ip_s};
    pt_cmd.key   = {{IpW{1'b0}}, port_s};
    ex_cmd.value = nv_q;
    ad_cmd.value = nv_q;
    pt_cmd.value = nv_q;
    ex_cmd.search = 1'b1;
    ad_cmd.search = 1'b1;
    pt_cmd.search = 1'b1;
    ex_cmd.wr_free = !ex_hit;
    ad_cmd.wr_free = !ad_hit;
    pt_cmd.wr_free = !pt_hit;
    if (phase && op == CMD_INSERT) begin
      ex_cmd.write = (kind == KIND_EXACT);
      ad_cmd.write = (kind == KIND_ADDR);
      pt_cmd.write = (kind == KIND_PORT);
    end
  end

  natwr_table #(.Entries(EXACT_ENTRIES), .KeyW(ValW)) u_exact (
    .clk(clk), .rst(rst), .cmd(ex_cmd), .result(ex_res)
  );
  natwr_table #(.Entries(ADDR_ENTRIES), .KeyW(IpW)) u_addr (
    .clk(clk), .rst(rst), .cmd(ad_cmd), .result(ad_res)
  );
  natwr_table #(.Entries(PORT_ENTRIES), .KeyW(PortW)) u_port (
    .clk(clk), .rst(rst), .cmd(pt_cmd), .result(pt_res)
  );

  // Advance the two-phase control.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else begin
      phase <= start && !phase;
    end
  end

  // Capture the item on transfer.
  always_ff @(posedge clk) begin
    if (start && !phase) begin
      op     <= cmd;
      kind   <= rule_kind;
      ip_q   <= match_ip;
      port_q <= match_port;
      nv_q   <= {new_ip, new_port};
    end
  end

  // Register the search outcome of the key under search.
  always_ff @(posedge clk) begin
    ex_hit  <= ex_res.hit;
    ad_hit  <= ad_res.hit;
    pt_hit  <= pt_res.hit;
    ex_free <= ex_res.free_seen;
    ad_free <= ad_res.free_seen;
    pt_free <= pt_res.free_seen;
    ex_val  <= ex_res.value;
    ad_val  <= ad_res.value;
    pt_val  <= pt_res.value;
  end

  // Form the result.
  always_comb begin
    logic             hit;
    logic             free;
    logic [ValW-1:0]  val;
    hit  = 1'b0;
    free = 1'b0;
    val  = '0;
    done = phase;
    status       = ST_MISS;
    matched_kind = KIND_EXACT;
    out_ip   = '0;
    out_port = '0;
    if (op == CMD_INSERT) begin
      case (kind)
        KIND_EXACT: begin hit = ex_hit; free = ex_free; end
        KIND_ADDR:  begin hit = ad_hit; free = ad_free; end
        KIND_PORT:  begin hit = pt_hit; free = pt_free; end
        default:    begin hit = 1'b0;   free = 1'b0;    end
      endcase
      if (kind != KIND_NONE) begin
        status = hit ? ST_REPLACED : (free ? ST_OK : ST_FULL);
      end
    end else begin
      if (ex_hit) begin
        hit = 1'b1; val = ex_val; matched_kind = KIND_EXACT;
      end else if (ad_hit) begin
        hit = 1'b1; val = ad_val; matched_kind = KIND_ADDR;
      end else if (pt_hit) begin
        hit = 1'b1; val = pt_val; matched_kind = KIND_PORT;
      end
      if (hit) begin
        status   = ST_OK;
        out_ip   = val[ValW-1:PortW];
        out_port = val[PortW-1:0];
      end
    end
  end

endmodule

// ===== design/natwr_checker.sv =====
// ----------------------------------------------------------------------------
// NAT rule lookup checker
// Port-level properties of the lookup core, bound to the top level.
// ----------------------------------------------------------------------------
module natwr_checker import natwr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [1:0]  matched_kind,
  input logic [31:0] out_ip,
  input logic [15:0] out_port
);

  // Every transfer gives a result in the next cycle.
  a_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done) else $error("missing result");

  // A result only follows a transfer.
  a_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy)) else $error("result without transfer");

  // Results with a status other than OK carry zero translation and kind.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (out_ip == '0 && out_port == '0 && matched_kind == '0))
    else $error("nonzero fields on non-hit");

  // Never two results back to back.
  a_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("back to back results");

endmodule

bind nat_wildcard_rule_lookup_core natwr_checker u_natwr_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .matched_kind(matched_kind), .out_ip(out_ip),
  .out_port(out_port)
);

// ===== dv/nat_wildcard_rule_lookup_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NAT wildcard rule lookup core testbench
// Drives insert and lookup commands with random gaps and checks every result
// against a scoreboard that keeps its own copy of the three rule tables.
// ----------------------------------------------------------------------------
module nat_wildcard_rule_lookup_core_tb;
  import natwr_pkg::*;

  localparam int Depth     = DefExactEntries;
  localparam int PoolSize  = 72;
  localparam int RandItems = 930;
  localparam int IdleLimit = 2000;

  typedef struct {
    logic             cmd;
    logic [1:0]       kind;
    logic [IpW-1:0]   ip;
    logic [PortW-1:0] port;
    logic [IpW-1:0]   nip;
    logic [PortW-1:0] nport;
  } rule_cmd_t;

  typedef struct {
    status_t          st;
    kind_t            mk;
    logic [IpW-1:0]   ip;
    logic [PortW-1:0] port;
  } xlate_t;

  // Scoreboard: mirror of the rule tables and the queue of pending results
  class nat_table_sb;
    logic [ValW-1:0] keys[3][Depth];
    logic [ValW-1:0] vals[3][Depth];
    bit              valid[3][Depth];
    xlate_t          pending[$];
    int              errors;

    function automatic logic [ValW-1:0] key_of(int t, rule_cmd_t c);
      case (t)
        KIND_EXACT: return {c.ip, c.port};
        KIND_ADDR:  return {{PortW{1'b0}}, c.ip};
        default:    return {{IpW{1'b0}}, c.port};
      endcase
    endfunction

    // Compute the result of one accepted transfer and update the tables
    function void note(rule_cmd_t c);
      xlate_t r;
      int     free_idx;
      bit     found;
      logic [ValW-1:0] k;
      r = '{ST_MISS, KIND_EXACT, '0, '0};
      if (c.cmd == CMD_INSERT) begin
        if (c.kind != KIND_NONE) begin
          k = key_of(c.kind, c);
          free_idx = -1;
          found = 0;
          for (int i = 0; i < Depth; i++) begin
            if (valid[c.kind][i]) begin
              if (!found && keys[c.kind][i] == k) begin
                vals[c.kind][i] = {c.nip, c.nport};
                found = 1;
              end
            end else if (free_idx < 0) begin
              free_idx = i;
            end
          end
          if (found) r.st = ST_REPLACED;
          else if (free_idx < 0) r.st = ST_FULL;
          else begin
            keys[c.kind][free_idx] = k;
            vals[c.kind][free_idx] = {c.nip, c.nport};
            valid[c.kind][free_idx] = 1;
            r.st = ST_OK;
          end
        end
      end else begin
        found = 0;
        for (int t = 0; t < 3 && !found; t++) begin
          k = key_of(t, c);
          for (int i = 0; i < Depth && !found; i++) begin
            if (valid[t][i] && keys[t][i] == k) begin
              found = 1;
              r.st = ST_OK;
              r.mk = kind_t'(t);
              {r.ip, r.port} = vals[t][i];
            end
          end
        end
      end
      pending.push_back(r);
    endfunction

    // Compare one result with the oldest expectation
    function void check(xlate_t a);
      xlate_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, a.st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.st !== e.st) begin
        $display("%0t: status exp %0d got %0d", $time, e.st, a.st);
        errors++;
      end
      if (a.mk !== e.mk) begin
        $display("%0t: matched_kind exp %0d got %0d", $time, e.mk, a.mk);
        errors++;
      end
      if (a.ip !== e.ip) begin
        $display("%0t: out_ip exp %h got %h", $time, e.ip, a.ip);
        errors++;
      end
      if (a.port !== e.port) begin
        $display("%0t: out_port exp %h got %h", $time, e.port, a.port);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic             cmd;
  logic [1:0]       rule_kind;
  logic [IpW-1:0]   match_ip;
  logic [PortW-1:0] match_port;
  logic [IpW-1:0]   new_ip;
  logic [PortW-1:0] new_port;
  logic             done;
  logic [1:0]       status;
  logic [1:0]       matched_kind;
  logic [IpW-1:0]   out_ip;
  logic [PortW-1:0] out_port;

  nat_table_sb      sb;
  logic [IpW-1:0]   ip_pool[PoolSize];
  logic [PortW-1:0] port_pool[PoolSize];
  int               idle_cycles;

  nat_wildcard_rule_lookup_core uut (
    .clk, .rst, .start, .busy, .cmd, .rule_kind, .match_ip, .match_port,
    .new_ip, .new_port, .done, .status, .matched_kind, .out_ip, .out_port
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Check every result strobe
  always @(posedge clk) begin
    if (!rst && done)
      sb.check('{status_t'(status), kind_t'(matched_kind), out_ip, out_port});
  end

  // Watchdog: count cycles with no transfer and no result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drive one command after a random gap and hold it until accepted
  task automatic send(rule_cmd_t c);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      @(negedge clk);
      start <= 0;
    end
    @(negedge clk);
    start      <= 1;
    cmd        <= c.cmd;
    rule_kind  <= c.kind;
    match_ip   <= c.ip;
    match_port <= c.port;
    new_ip     <= c.nip;
    new_port   <= c.nport;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note(c);
  endtask

  function automatic rule_cmd_t mk_cmd(logic c, logic [1:0] k, logic [IpW-1:0] ip,
                                       logic [PortW-1:0] port, logic [IpW-1:0] nip,
                                       logic [PortW-1:0] nport);
    rule_cmd_t r;
    r = '{c, k, ip, port, nip, nport};
    return r;
  endfunction

  // Random command, keys mostly drawn from the pools so tables fill and hit
  function automatic rule_cmd_t rand_cmd();
    rule_cmd_t r;
    int        sel;
    r.cmd   = ($urandom_range(0, 99) < 45) ? CMD_INSERT : CMD_LOOKUP;
    sel     = $urandom_range(0, PoolSize - 1);
    r.ip    = ip_pool[sel];
    r.port  = port_pool[sel];
    if ($urandom_range(0, 3) == 0) r.port = port_pool[$urandom_range(0, PoolSize - 1)];
    if ($urandom_range(0, 3) == 0) r.ip = ip_pool[$urandom_range(0, PoolSize - 1)];
    if ($urandom_range(0, 6) == 0) r.ip = $urandom;
    if ($urandom_range(0, 6) == 0) r.port = 16'($urandom);
    r.kind  = ($urandom_range(0, 19) == 0) ? KIND_NONE : 2'($urandom_range(0, 2));
    r.nip   = $urandom;
    r.nport = 16'($urandom);
    return r;
  endfunction

  initial begin
    sb = new();
    rst = 1;
    start = 0;
    cmd = CMD_INSERT;
    rule_kind = KIND_EXACT;
    match_ip = '0;
    match_port = '0;
    new_ip = '0;
    new_port = '0;
    for (int i = 0; i < PoolSize; i++) begin
      ip_pool[i]   = $urandom;
      port_pool[i] = 16'($urandom);
    end
    ip_pool[0] = '0;
    port_pool[0] = '0;
    ip_pool[1] = '1;
    port_pool[1] = '1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: empty lookup, extremes, replace, unknown kind, priority
    send(mk_cmd(CMD_LOOKUP, KIND_EXACT, '0, '0, '1, '1));
    send(mk_cmd(CMD_INSERT, KIND_EXACT, '0, '0, '1, '1));
    send(mk_cmd(CMD_INSERT, KIND_EXACT, '1, '1, '0, '0));
    send(mk_cmd(CMD_LOOKUP, KIND_EXACT, '0, '0, '0, '0));
    send(mk_cmd(CMD_LOOKUP, KIND_EXACT, '1, '1, '0, '0));
    send(mk_cmd(CMD_INSERT, KIND_EXACT, '1, '1, 32'h1234_5678, 16'hbeef));
    send(mk_cmd(CMD_LOOKUP, KIND_EXACT, '1, '1, '0, '0));
    send(mk_cmd(CMD_INSERT, KIND_ADDR, '1, 16'h0042, 32'ha5a5_a5a5, 16'h5a5a));
    send(mk_cmd(CMD_LOOKUP, KIND_EXACT, '1, 16'h7777, '0, '0));
    send(mk_cmd(CMD_INSERT, KIND_PORT, 32'h0bad_cafe, '0, 32'h0f0f_0f0f, 16'hf0f0));
    send(mk_cmd(CMD_LOOKUP, KIND_EXACT, 32'h1111_1111, '0, '0, '0));
    send(mk_cmd(CMD_INSERT, KIND_ADDR, '0, '1, 32'hdead_0001, 16'h0001));
    send(mk_cmd(CMD_LOOKUP, KIND_EXACT, '0, '0, '0, '0));
    send(mk_cmd(CMD_LOOKUP, KIND_EXACT, '0, 16'h1234, '0, '0));
    send(mk_cmd(CMD_INSERT, KIND_ADDR, '1, '0, 32'h0000_0002, 16'h0002));
    send(mk_cmd(CMD_INSERT, KIND_PORT, '1, '0, 32'h0000_0003, 16'h0003));
    send(mk_cmd(CMD_INSERT, KIND_NONE, '1, '1, '1, '1));
    send(mk_cmd(CMD_LOOKUP, KIND_NONE, 32'h2222_2222, '0, '1, '1));
    send(mk_cmd(CMD_LOOKUP, KIND_PORT, 32'h3333_3333, 16'h4444, '1, '1));
    send(mk_cmd(CMD_INSERT, KIND_PORT, '0, '1, 32'h8000_0000, 16'h8000));
    send(mk_cmd(CMD_LOOKUP, KIND_EXACT, 32'h5555_5555, '1, '0, '0));

    // Random: pooled keys so tables fill up, replace and hit often
    for (int n = 0; n < RandItems; n++)
      send(rand_cmd());

    @(negedge clk);
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/natwr_pkg.sv
design/natwr_cell.sv
design/natwr_table.sv
design/nat_wildcard_rule_lookup_core.sv
design/natwr_checker.sv
dv/nat_wildcard_rule_lookup_core_tb.sv
